// ===== hw/rtl/itoa_pkg.sv =====
package itoa_pkg;

   // value and digit store geometry
   localparam int VALUE_WIDTH = 64;
   localparam int STORE_DEPTH = 20;
   localparam int DIGIT_W = 4;
   localparam int STORE_W = STORE_DEPTH * DIGIT_W;
   localparam int INDEX_W = $clog2(STORE_DEPTH);

   // double dabble: bits folded into the digits per cycle
   localparam int DABBLE_BITS = 4;
   localparam int DABBLE_STEPS = (VALUE_WIDTH + DABBLE_BITS - 1) / DABBLE_BITS;
   localparam int SHIFT_W = DABBLE_STEPS * DABBLE_BITS;
   localparam int STEP_W = $clog2(DABBLE_STEPS);

   // job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // character codes
   localparam int CHAR_W = 7;
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_A = 7'h41;
   localparam logic [CHAR_W-1:0] CHAR_X = 7'h78;
   localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

   typedef struct packed {
      logic [63:0] value;
      logic        func;
   } req_payload_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              last;
   } rsp_payload_type;

   // classified job handed from front to back
   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic                   hex;
      logic                   zero;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // ascii code of one digit, uppercase hex letters
   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < DIGIT_TEN) begin
         c = CHAR_ZERO + CHAR_W'(d);
      end else begin
         c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/itoa_front.sv =====
module itoa_front
   import itoa_pkg::*;
(
   input  logic             req_valid,
   output logic             req_ready,
   input  req_payload_type  req_payload,
   input  queue_status_type queue_status,
   output push_type         push
);

   logic [VALUE_WIDTH-1:0] masked;

   // accept whenever the queue has a free slot
   assign req_ready = !queue_status.full;

   // classify: mask to the value width, mode, zero value
   assign masked = req_payload.value[VALUE_WIDTH-1:0];

   always_comb begin
      push.valid = req_valid && !queue_status.full;
      push.job.value = masked;
      push.job.hex = req_payload.func;
      push.job.zero = (masked == '0);
   end

endmodule

// ===== hw/rtl/itoa_queue.sv =====
module itoa_queue
   import itoa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  push_type         push,
   input  logic             pop,
   output job_type          head,
   output queue_status_type status
);

   job_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign status.full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push = push.valid && !status.full;
   assign do_pop = pop && !status.empty;
   assign head = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.job;
      end
   end

endmodule

// ===== hw/rtl/itoa_back.sv =====
module itoa_back
   import itoa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  job_type          head,
   input  queue_status_type queue_status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_payload_type  rsp_payload
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CONV = 3'd1;
   localparam logic [2:0] ST_SIZE = 3'd2;
   localparam logic [2:0] ST_PRE0 = 3'd3;
   localparam logic [2:0] ST_PREX = 3'd4;
   localparam logic [2:0] ST_EMIT = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [STORE_W-1:0] digits_ff, digits_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [INDEX_W-1:0] ptr_ff, ptr_in;
   logic               hex_ff, hex_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_payload_ff, rsp_payload_in;

   logic               out_free;
   logic [STORE_W-1:0] dab_digits;
   logic [SHIFT_W-1:0] dab_shift;
   logic [INDEX_W-1:0] top_index;
   logic [DIGIT_W-1:0] cur_digit;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop = (state_ff == ST_IDLE) && !queue_status.empty;
   assign cur_digit = digits_ff[ptr_ff * DIGIT_W +: DIGIT_W];
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // double dabble: fold a few value bits into the bcd digits, msb first
   always_comb begin
      dab_digits = digits_ff;
      dab_shift = shift_ff;
      for (int b = 0; b < DABBLE_BITS; b++) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            if (dab_digits[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
               dab_digits[i*DIGIT_W +: DIGIT_W] = dab_digits[i*DIGIT_W +: DIGIT_W] + 4'd3;
            end
         end
         dab_digits = {dab_digits[STORE_W-2:0], dab_shift[SHIFT_W-1]};
         dab_shift = {dab_shift[SHIFT_W-2:0], 1'b0};
      end
   end

   // index of the most significant nonzero digit, zero when all are zero
   always_comb begin
      top_index = '0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         if (digits_ff[i*DIGIT_W +: DIGIT_W] != '0) begin
            top_index = INDEX_W'(i);
         end
      end
   end

   // sequencer and output register
   always_comb begin
      state_in = state_ff;
      digits_in = digits_ff;
      shift_in = shift_ff;
      step_in = step_ff;
      ptr_in = ptr_ff;
      hex_in = hex_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_status.empty) begin
               hex_in = head.hex;
               step_in = '0;
               shift_in = SHIFT_W'(head.value);
               if (head.hex || head.zero) begin
                  digits_in = STORE_W'(head.value);
                  state_in = ST_SIZE;
               end else begin
                  digits_in = '0;
                  state_in = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            digits_in = dab_digits;
            shift_in = dab_shift;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DABBLE_STEPS - 1)) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            ptr_in = top_index;
            state_in = hex_ff ? ST_PRE0 : ST_EMIT;
         end
         ST_PRE0: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_payload_in.char_code = CHAR_ZERO;
               rsp_payload_in.last = 1'b0;
               state_in = ST_PREX;
            end
         end
         ST_PREX: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_payload_in.char_code = CHAR_X;
               rsp_payload_in.last = 1'b0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_payload_in.char_code = digit_char(cur_digit);
               rsp_payload_in.last = (ptr_ff == '0);
               if (ptr_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in = ptr_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff <= '0;
         ptr_ff <= '0;
         hex_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff <= step_in;
         ptr_ff <= ptr_in;
         hex_ff <= hex_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      digits_ff <= digits_in;
      shift_ff <= shift_in;
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

// ===== hw/rtl/integer_to_ascii_digits_top.sv =====
// channel | ports                            | beat
// req     | req_valid req_ready req_payload  | value (64b), func (1b: 0 dec, 1 hex)
// rsp     | rsp_valid rsp_ready rsp_payload  | char_code (7b), last (1b)
//
// decimal: a load state, double dabble steps (4 bits a cycle), a sizing state,
// then one character a cycle while rsp is not stalled, for up to 20 digits
// hex: load, sizing, "0x" and up to 16 digits
// a two-entry job queue takes new beats while the back end is busy
// reset is synchronous and clears all control state; a stalled rsp holds the back end
module integer_to_ascii_digits_top
   import itoa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   queue_status_type queue_status;
   push_type         push;
   job_type          head;
   logic             pop;

   // accept and classify
   itoa_front u_front (
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .queue_status (queue_status),
      .push         (push)
   );

   // job queue
   itoa_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (queue_status)
   );

   // digit extraction and character output
   itoa_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload)
   );

endmodule

// ===== hw/rtl/itoa_checker.sv =====
module itoa_checker
   import itoa_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   // no result beat right out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled rsp beat changed");

   // result valid is always known once out of reset
   assert property (@(posedge clock) disable iff (reset)
      !$isunknown(rsp_valid))
      else $error("rsp_valid unknown");

   // the hex prefix never ends a conversion
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (rsp_payload.char_code == CHAR_X) |-> !rsp_payload.last)
      else $error("prefix character flagged last");

endmodule

bind integer_to_ascii_digits_top itoa_checker u_checker (.*);

// ===== test/integer_to_ascii_digits_top_tb.sv =====
module integer_to_ascii_digits_top_tb;
   import itoa_pkg::*;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;

   // characters still owed by the block, oldest first
   rsp_payload_type expected_chars[$];
   int              error_count;
   int              send_idle_pct;
   int              recv_stall_pct;

   // directed rows: an empty text means the predictor supplies the characters
   logic [63:0] row_value[$];
   logic        row_func[$];
   string       row_text[$];

   integer_to_ascii_digits_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      error_count++;
   endtask

   task automatic queue_char(input logic [CHAR_W-1:0] code, input logic is_last);
      rsp_payload_type c;
      c.char_code = code;
      c.last = is_last;
      expected_chars.push_back(c);
   endtask

   // text of one value: masked, split into digits low first, then emitted high first
   task automatic spell_value(input logic [63:0] raw, input logic hex);
      logic [63:0]        rest;
      logic [63:0]        base;
      logic [63:0]        mask;
      logic [DIGIT_W-1:0] digits[0:STORE_DEPTH-1];
      logic [DIGIT_W-1:0] d;
      logic [CHAR_W-1:0]  code;
      int                 n;
      mask = (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);
      rest = raw & mask;
      base = hex ? 64'd16 : 64'd10;
      n = 0;
      while (rest != 64'd0 && n < STORE_DEPTH) begin
         digits[n] = DIGIT_W'(rest % base);
         rest = rest / base;
         n++;
      end
      // zero still prints one digit
      if (n == 0) begin
         digits[0] = '0;
         n = 1;
      end
      if (hex) begin
         queue_char(CHAR_ZERO, 1'b0);
         queue_char(CHAR_X, 1'b0);
      end
      for (int i = n - 1; i >= 0; i--) begin
         d = digits[i];
         code = (d < DIGIT_TEN) ? CHAR_ZERO + CHAR_W'(d) : CHAR_A + CHAR_W'(d - DIGIT_TEN);
         queue_char(code, i == 0);
      end
   endtask

   task automatic add_row(input logic [63:0] v, input logic f, input string text);
      row_value.push_back(v);
      row_func.push_back(f);
      row_text.push_back(text);
   endtask

   // offer one beat, at times after a random gap; valid stays high between back-to-back beats
   task automatic send_value(input logic [63:0] v, input logic f, input string text);
      req_payload_type p;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do begin
            req_payload <= {$urandom, $urandom, 1'($urandom)};
            @(posedge clock);
         end while ($urandom_range(99) < send_idle_pct);
      end
      p.value = v;
      p.func = f;
      req_valid <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
      if (text.len() == 0) begin
         spell_value(v, f);
      end else begin
         for (int i = 0; i < text.len(); i++) begin
            queue_char(CHAR_W'(text[i]), i == text.len() - 1);
         end
      end
   endtask

   // random value of random bit length, so short and long texts both show up
   function automatic logic [63:0] random_value();
      logic [63:0] v;
      int          bits;
      v = {$urandom, $urandom};
      bits = $urandom_range(64, 0);
      if ($urandom_range(3) == 0) begin
         bits = 64;
      end
      if (bits < 64) begin
         v = v & ((64'd1 << bits) - 64'd1);
      end
      return v;
   endfunction

   // result side: random stalls, every accepted beat checked against the oldest expectation
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected beat char 0x%02h last %0b",
                  rsp_payload.char_code, rsp_payload.last));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_payload.char_code !== want.char_code) begin
                  report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h",
                     rsp_payload.char_code, want.char_code));
               end
               if (rsp_payload.last !== want.last) begin
                  report_mismatch($sformatf("last %0b, expected %0b",
                     rsp_payload.last, want.last));
               end
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // stimulus
   initial begin
      int idle_of[4];
      int stall_of[4];
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      error_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      idle_of[0] = 0;
      idle_of[1] = 81;
      idle_of[2] = 0;
      idle_of[3] = 20;
      stall_of[0] = 0;
      stall_of[1] = 0;
      stall_of[2] = 81;
      stall_of[3] = 20;

      // zero, single digits, digit count boundaries, full range, hex letters
      add_row(64'd0, 1'b0, "0");
      add_row(64'd0, 1'b1, "0x0");
      add_row(64'd1, 1'b0, "1");
      add_row(64'd9, 1'b0, "9");
      add_row(64'd10, 1'b0, "10");
      add_row(64'hA, 1'b1, "0xA");
      add_row(64'hF, 1'b1, "0xF");
      add_row(64'h10, 1'b1, "0x10");
      add_row(64'hFF, 1'b1, "0xFF");
      add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, "18446744073709551615");
      add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "0xFFFFFFFFFFFFFFFF");
      add_row(64'd9999999999999999999, 1'b0, "9999999999999999999");
      add_row(64'd10000000000000000000, 1'b0, "10000000000000000000");
      add_row(64'h8000_0000_0000_0000, 1'b1, "0x8000000000000000");
      add_row(64'h0123_4567_89AB_CDEF, 1'b1, "0x123456789ABCDEF");
      add_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, "");
      add_row(64'h5555_5555_5555_5555, 1'b0, "");
      add_row(64'h5555_5555_5555_5555, 1'b1, "");
      add_row(64'hFEDC_BA98_7654_3210, 1'b1, "");
      add_row(64'd12345, 1'b0, "");
      add_row(64'd4294967296, 1'b0, "");
      add_row(64'hDEAD_BEEF, 1'b1, "");

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < row_value.size(); i++) begin
         send_value(row_value[i], row_func[i], row_text[i]);
      end

      // random part over the idling phases
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_of[ph];
         recv_stall_pct = stall_of[ph];
         repeat (20) begin
            send_value(random_value(), 1'($urandom), "");
         end
      end

      req_valid <= 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule
